[design/apr_pkg.sv]
// Shared types, constants and fixed-point helpers for the Aliev-Panfilov RHS pipeline.
package apr_pkg;

    localparam int W = 32;
    localparam int F = 20;

    // Long division of the magnitude (shifted left by F) by the divisor magnitude.
    localparam int DIV_BITS   = W + F;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = (DIV_BITS + DIV_STEPS - 1) / DIV_STEPS;
    localparam int NUM_W      = DIV_STAGES * DIV_STEPS;

    // Sideband carried through the divider: du, negated r term, flag.
    localparam int SIDE_W = 2 * W + 1;

    localparam logic signed [W-1:0] FX_MAX  = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] FX_MIN  = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] FX_ONE  = W'(1 << F);
    localparam logic signed [W-1:0] FX_NONE = -FX_ONE;

    localparam logic [2*W-1:0] MAG_POS_LIM = {{(W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [2*W-1:0] MAG_NEG_LIM = MAG_POS_LIM + 1'b1;

    localparam logic [2:0] REG_A   = 3'd0;
    localparam logic [2:0] REG_K   = 3'd1;
    localparam logic [2:0] REG_MU1 = 3'd2;
    localparam logic [2:0] REG_MU2 = 3'd3;
    localparam logic [2:0] REG_EPS = 3'd4;

    localparam logic signed [W-1:0] RST_A   = W'(157286);
    localparam logic signed [W-1:0] RST_K   = W'(8388608);
    localparam logic signed [W-1:0] RST_MU1 = W'(209715);
    localparam logic signed [W-1:0] RST_MU2 = W'(314573);
    localparam logic signed [W-1:0] RST_EPS = W'(2097);

    typedef struct packed {
        logic signed [W-1:0] v;
        logic                f;
    } fx_t;

    function automatic fx_t fx_clamp(logic signed [W:0] s);
        fx_t r;
        if (s[W] != s[W-1])
        begin
            r.v = s[W] ? FX_MIN : FX_MAX;
            r.f = 1'b1;
        end
        else
        begin
            r.v = s[W-1:0];
            r.f = 1'b0;
        end
        return r;
    endfunction

    function automatic fx_t fx_add(logic signed [W-1:0] x, logic signed [W-1:0] y);
        logic signed [W:0] s;
        s = {x[W-1], x} + {y[W-1], y};
        return fx_clamp(s);
    endfunction

    function automatic fx_t fx_sub(logic signed [W-1:0] x, logic signed [W-1:0] y);
        logic signed [W:0] s;
        s = {x[W-1], x} - {y[W-1], y};
        return fx_clamp(s);
    endfunction

    function automatic fx_t fx_neg(logic signed [W-1:0] x);
        return fx_sub('0, x);
    endfunction

    function automatic logic [W-1:0] fx_mag(logic signed [W-1:0] x);
        logic [W-1:0] u;
        u = x;
        return x[W-1] ? (~u + 1'b1) : u;
    endfunction

    // Signed result from a magnitude, saturating to the word range.
    function automatic fx_t fx_from_mag(logic neg, logic [2*W-1:0] m);
        fx_t r;
        if (!neg)
        begin
            if (m > MAG_POS_LIM)
            begin
                r.v = FX_MAX;
                r.f = 1'b1;
            end
            else
            begin
                r.v = m[W-1:0];
                r.f = 1'b0;
            end
        end
        else
        begin
            if (m > MAG_NEG_LIM)
            begin
                r.v = FX_MIN;
                r.f = 1'b1;
            end
            else
            begin
                r.v = ~m[W-1:0] + 1'b1;
                r.f = 1'b0;
            end
        end
        return r;
    endfunction

    // Product truncated toward zero.
    function automatic fx_t fx_mul(logic signed [W-1:0] x, logic signed [W-1:0] y);
        logic [W-1:0]   ma;
        logic [W-1:0]   mb;
        logic [2*W-1:0] p;
        ma = fx_mag(x);
        mb = fx_mag(y);
        p  = ma * mb;
        return fx_from_mag(x[W-1] ^ y[W-1], p >> F);
    endfunction

endpackage

[design/apr_div.sv]
// Pipelined restoring divider: signed fixed-point quotient, four bits per stage.
module apr_div
    import apr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_vld,
    input  logic signed [W-1:0] num,
    input  logic signed [W-1:0] den,
    input  logic [SIDE_W-1:0]   side_in,
    output logic                out_vld,
    output fx_t                 quot,
    output logic [SIDE_W-1:0]   side_out
);

    logic              vld  [0:DIV_STAGES];
    logic [W:0]        rem  [0:DIV_STAGES];
    logic [NUM_W-1:0]  numb [0:DIV_STAGES];
    logic [NUM_W-1:0]  quo  [0:DIV_STAGES];
    logic [W-1:0]      dmag [0:DIV_STAGES];
    logic              neg  [0:DIV_STAGES];
    logic              dz   [0:DIV_STAGES];
    logic              nneg [0:DIV_STAGES];
    logic [SIDE_W-1:0] side [0:DIV_STAGES];

    assign vld[0]  = in_vld;
    assign rem[0]  = '0;
    assign numb[0] = NUM_W'({fx_mag(num), {F{1'b0}}});
    assign quo[0]  = '0;
    assign dmag[0] = fx_mag(den);
    assign neg[0]  = num[W-1] ^ den[W-1];
    assign dz[0]   = (den == '0);
    assign nneg[0] = num[W-1];
    assign side[0] = side_in;

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_stage
        logic [W:0]       rem_next;
        logic [NUM_W-1:0] numb_next;
        logic [NUM_W-1:0] quo_next;

        always_comb
        begin : step
            logic [W:0]       r;
            logic [NUM_W-1:0] n;
            logic [NUM_W-1:0] q;
            r = rem[g];
            n = numb[g];
            q = quo[g];
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                r = {r[W-1:0], n[NUM_W-1]};
                n = n << 1;
                q = q << 1;
                if (r >= {1'b0, dmag[g]})
                begin
                    r    = r - {1'b0, dmag[g]};
                    q[0] = 1'b1;
                end
            end
            rem_next  = r;
            numb_next = n;
            quo_next  = q;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld[g+1] <= 1'b0;
            end
            else if (en)
            begin
                vld[g+1] <= vld[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem[g+1]  <= rem_next;
                numb[g+1] <= numb_next;
                quo[g+1]  <= quo_next;
                dmag[g+1] <= dmag[g];
                neg[g+1]  <= neg[g];
                dz[g+1]   <= dz[g];
                nneg[g+1] <= nneg[g];
                side[g+1] <= side[g];
            end
        end
    end

    always_comb
    begin
        if (dz[DIV_STAGES])
        begin
            quot.v = nneg[DIV_STAGES] ? FX_MIN : FX_MAX;
            quot.f = 1'b1;
        end
        else
        begin
            quot = fx_from_mag(neg[DIV_STAGES], (2*W)'(quo[DIV_STAGES]));
        end
    end

    assign out_vld  = vld[DIV_STAGES];
    assign side_out = side[DIV_STAGES];

    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld && dz[DIV_STAGES] |-> quot.f)
        else $error("zero divisor without flag");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(out_vld) && $stable(side_out))
        else $error("divider moved while frozen");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld && !dz[DIV_STAGES] |-> rem[DIV_STAGES] < {1'b0, dmag[DIV_STAGES]})
        else $error("remainder not below divisor");

endmodule

[design/aliev_panfilov_rhs_top.sv]
// Top level of the Aliev-Panfilov right-hand-side pipeline with its coefficient registers.
// Takes one (u, v) beat per clock while not stalled and returns (du, dv, range_flag); the
// pipeline has six polynomial stages, thirteen divider stages that each resolve four quotient
// bits of v/(mu2+u), and four stages for the recovery term and the output register. A stall
// on the output freezes the whole pipeline in place, and the input stalls with it.
module aliev_panfilov_rhs_top
    import apr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [W-1:0]        cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [W-1:0] u_val,
    input  logic signed [W-1:0] v_val,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [W-1:0] du_val,
    output logic signed [W-1:0] dv_val,
    output logic                range_flag
);

    logic signed [W-1:0] coef_a_reg, coef_k_reg, coef_mu1_reg, coef_mu2_reg, coef_eps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg   <= RST_A;
            coef_k_reg   <= RST_K;
            coef_mu1_reg <= RST_MU1;
            coef_mu2_reg <= RST_MU2;
            coef_eps_reg <= RST_EPS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_A:   coef_a_reg   <= cfg_data;
                REG_K:   coef_k_reg   <= cfg_data;
                REG_MU1: coef_mu1_reg <= cfg_data;
                REG_MU2: coef_mu2_reg <= cfg_data;
                REG_EPS: coef_eps_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic en;
    logic out_valid_reg;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // Stage registers.
    logic                s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg, s6_vld_reg;
    logic                s7_vld_reg, s8_vld_reg, s9_vld_reg;
    logic signed [W-1:0] s1_u_reg, s1_v_reg, s1_au_reg, s1_c_reg, s1_uu_reg, s1_r_reg;
    logic signed [W-1:0] s1_s0_reg, s1_uv_reg;
    logic                s1_f_reg;
    logic signed [W-1:0] s2_u_reg, s2_v_reg, s2_au_reg, s2_cu_reg, s2_uuu_reg, s2_rk_reg;
    logic signed [W-1:0] s2_s0_reg, s2_uv_reg;
    logic                s2_f_reg;
    logic signed [W-1:0] s3_v_reg, s3_au_reg, s3_cuu_reg, s3_uuu_reg, s3_ur_reg;
    logic signed [W-1:0] s3_s0_reg, s3_uv_reg;
    logic                s3_f_reg;
    logic signed [W-1:0] s4_v_reg, s4_t_reg, s4_rn_reg, s4_s0_reg, s4_uv_reg;
    logic                s4_f_reg;
    logic signed [W-1:0] s5_v_reg, s5_tk_reg, s5_rn_reg, s5_s0_reg, s5_uv_reg;
    logic                s5_f_reg;
    logic signed [W-1:0] s6_v_reg, s6_du_reg, s6_rn_reg, s6_s0_reg;
    logic                s6_f_reg;
    logic signed [W-1:0] s7_q_reg, s7_du_reg, s7_rn_reg;
    logic                s7_f_reg;
    logic signed [W-1:0] s8_sm_reg, s8_du_reg, s8_rn_reg;
    logic                s8_f_reg;
    logic signed [W-1:0] s9_s_reg, s9_du_reg, s9_rn_reg;
    logic                s9_f_reg;
    logic signed [W-1:0] du_reg, dv_reg;
    logic                flag_reg;

    // Stage 1 terms.
    fx_t m_au, c1, m_uu, na, r0, r1, s0, m_uv;
    always_comb
    begin
        m_au = fx_mul(coef_a_reg, u_val);
        c1   = fx_sub(FX_NONE, coef_a_reg);
        m_uu = fx_mul(u_val, u_val);
        na   = fx_neg(coef_a_reg);
        r0   = fx_sub(na.v, FX_ONE);
        r1   = fx_add(r0.v, u_val);
        s0   = fx_add(coef_mu2_reg, u_val);
        m_uv = fx_mul(u_val, v_val);
    end

    fx_t m_cu, m_uuu, m_rk;
    always_comb
    begin
        m_cu  = fx_mul(s1_c_reg, s1_u_reg);
        m_uuu = fx_mul(s1_uu_reg, s1_u_reg);
        m_rk  = fx_mul(coef_k_reg, s1_r_reg);
    end

    fx_t m_cuu, m_ur, a_ur;
    always_comb
    begin
        m_cuu = fx_mul(s2_cu_reg, s2_u_reg);
        m_ur  = fx_mul(s2_u_reg, s2_rk_reg);
        a_ur  = fx_add(m_ur.v, s2_v_reg);
    end

    fx_t t1, t2, rn;
    always_comb
    begin
        t1 = fx_add(s3_cuu_reg, s3_au_reg);
        t2 = fx_add(s3_uuu_reg, t1.v);
        rn = fx_neg(s3_ur_reg);
    end

    fx_t m_tk, a_du, n_du;
    always_comb
    begin
        m_tk = fx_mul(coef_k_reg, s4_t_reg);
        a_du = fx_add(s5_uv_reg, s5_tk_reg);
        n_du = fx_neg(a_du.v);
    end

    logic              dq_vld;
    fx_t               dq;
    logic [SIDE_W-1:0] dq_side;

    apr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s6_vld_reg),
        .num      (s6_v_reg),
        .den      (s6_s0_reg),
        .side_in  ({s6_du_reg, s6_rn_reg, s6_f_reg}),
        .out_vld  (dq_vld),
        .quot     (dq),
        .side_out (dq_side)
    );

    fx_t m_sm, a_s, m_dv;
    always_comb
    begin
        m_sm = fx_mul(coef_mu1_reg, s7_q_reg);
        a_s  = fx_add(s8_sm_reg, coef_eps_reg);
        m_dv = fx_mul(s9_rn_reg, s9_s_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            s3_vld_reg    <= 1'b0;
            s4_vld_reg    <= 1'b0;
            s5_vld_reg    <= 1'b0;
            s6_vld_reg    <= 1'b0;
            s7_vld_reg    <= 1'b0;
            s8_vld_reg    <= 1'b0;
            s9_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg    <= in_valid;
            s2_vld_reg    <= s1_vld_reg;
            s3_vld_reg    <= s2_vld_reg;
            s4_vld_reg    <= s3_vld_reg;
            s5_vld_reg    <= s4_vld_reg;
            s6_vld_reg    <= s5_vld_reg;
            s7_vld_reg    <= dq_vld;
            s8_vld_reg    <= s7_vld_reg;
            s9_vld_reg    <= s8_vld_reg;
            out_valid_reg <= s9_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_u_reg   <= u_val;
            s1_v_reg   <= v_val;
            s1_au_reg  <= m_au.v;
            s1_c_reg   <= c1.v;
            s1_uu_reg  <= m_uu.v;
            s1_r_reg   <= r1.v;
            s1_s0_reg  <= s0.v;
            s1_uv_reg  <= m_uv.v;
            s1_f_reg   <= m_au.f | c1.f | m_uu.f | na.f | r0.f | r1.f | s0.f | m_uv.f;

            s2_u_reg   <= s1_u_reg;
            s2_v_reg   <= s1_v_reg;
            s2_au_reg  <= s1_au_reg;
            s2_cu_reg  <= m_cu.v;
            s2_uuu_reg <= m_uuu.v;
            s2_rk_reg  <= m_rk.v;
            s2_s0_reg  <= s1_s0_reg;
            s2_uv_reg  <= s1_uv_reg;
            s2_f_reg   <= s1_f_reg | m_cu.f | m_uuu.f | m_rk.f;

            s3_v_reg   <= s2_v_reg;
            s3_au_reg  <= s2_au_reg;
            s3_cuu_reg <= m_cuu.v;
            s3_uuu_reg <= s2_uuu_reg;
            s3_ur_reg  <= a_ur.v;
            s3_s0_reg  <= s2_s0_reg;
            s3_uv_reg  <= s2_uv_reg;
            s3_f_reg   <= s2_f_reg | m_cuu.f | m_ur.f | a_ur.f;

            s4_v_reg   <= s3_v_reg;
            s4_t_reg   <= t2.v;
            s4_rn_reg  <= rn.v;
            s4_s0_reg  <= s3_s0_reg;
            s4_uv_reg  <= s3_uv_reg;
            s4_f_reg   <= s3_f_reg | t1.f | t2.f | rn.f;

            s5_v_reg   <= s4_v_reg;
            s5_tk_reg  <= m_tk.v;
            s5_rn_reg  <= s4_rn_reg;
            s5_s0_reg  <= s4_s0_reg;
            s5_uv_reg  <= s4_uv_reg;
            s5_f_reg   <= s4_f_reg | m_tk.f;

            s6_v_reg   <= s5_v_reg;
            s6_du_reg  <= n_du.v;
            s6_rn_reg  <= s5_rn_reg;
            s6_s0_reg  <= s5_s0_reg;
            s6_f_reg   <= s5_f_reg | a_du.f | n_du.f;

            s7_q_reg   <= dq.v;
            s7_du_reg  <= dq_side[SIDE_W-1 -: W];
            s7_rn_reg  <= dq_side[W:1];
            s7_f_reg   <= dq_side[0] | dq.f;

            s8_sm_reg  <= m_sm.v;
            s8_du_reg  <= s7_du_reg;
            s8_rn_reg  <= s7_rn_reg;
            s8_f_reg   <= s7_f_reg | m_sm.f;

            s9_s_reg   <= a_s.v;
            s9_du_reg  <= s8_du_reg;
            s9_rn_reg  <= s8_rn_reg;
            s9_f_reg   <= s8_f_reg | a_s.f;

            du_reg     <= s9_du_reg;
            dv_reg     <= m_dv.v;
            flag_reg   <= s9_f_reg | m_dv.f;
        end
    end

    assign out_valid  = out_valid_reg;
    assign du_val     = du_reg;
    assign dv_val     = dv_reg;
    assign range_flag = flag_reg;

    // du is a negation, so it never reaches the smallest word; a saturated negation gives the largest.
    a_du_min_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (du_val == FX_MIN) |-> range_flag)
        else $error("du at minimum without flag");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(s6_vld_reg) && $stable(s9_vld_reg) && $stable(s1_vld_reg))
        else $error("pipeline moved while stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(du_val) && $stable(dv_val))
        else $error("result beat changed while stalled");

endmodule

[tb/sv/aliev_panfilov_rhs_top_tb.sv]
// Testbench for the Aliev-Panfilov right-hand-side pipeline: directed and random cells,
// checked against a fixed-point prediction.
module aliev_panfilov_rhs_top_tb
    import apr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct {
        logic signed [W-1:0] du;
        logic signed [W-1:0] dv;
        logic                flag;
    } deriv_t;

    class rhs_scoreboard;
        longint coef_a;
        longint coef_k;
        longint coef_mu1;
        longint coef_mu2;
        longint coef_eps;
        bit     sat;
        int     errors;
        deriv_t pending[$];

        function new();
            coef_a   = longint'(RST_A);
            coef_k   = longint'(RST_K);
            coef_mu1 = longint'(RST_MU1);
            coef_mu2 = longint'(RST_MU2);
            coef_eps = longint'(RST_EPS);
            errors   = 0;
        endfunction

        function void set_coef(logic [2:0] idx, logic signed [W-1:0] val);
            case (idx)
                REG_A:   coef_a   = longint'(val);
                REG_K:   coef_k   = longint'(val);
                REG_MU1: coef_mu1 = longint'(val);
                REG_MU2: coef_mu2 = longint'(val);
                REG_EPS: coef_eps = longint'(val);
                default: ;
            endcase
        endfunction

        function longint sat_word(longint x);
            if (x > longint'(FX_MAX))
            begin
                sat = 1'b1;
                return longint'(FX_MAX);
            end
            if (x < longint'(FX_MIN))
            begin
                sat = 1'b1;
                return longint'(FX_MIN);
            end
            return x;
        endfunction

        function longint add(longint x, longint y);
            return sat_word(x + y);
        endfunction

        function longint sub(longint x, longint y);
            return sat_word(x - y);
        endfunction

        function longint signed_mag(bit neg, longint unsigned m);
            if (!neg)
                return (m > 64'(FX_MAX)) ? sat_word(longint'(FX_MAX) + 1) : longint'(m);
            if (m > 64'h8000_0000)
                return sat_word(longint'(FX_MIN) - 1);
            return -longint'(m);
        endfunction

        function longint mul(longint x, longint y);
            longint unsigned mx;
            longint unsigned my;
            mx = (x < 0) ? -x : x;
            my = (y < 0) ? -y : y;
            return signed_mag((x < 0) != (y < 0), (mx * my) >> F);
        endfunction

        function longint quot(longint n, longint d);
            longint unsigned mn;
            longint unsigned md;
            if (d == 0)
            begin
                sat = 1'b1;
                return (n < 0) ? longint'(FX_MIN) : longint'(FX_MAX);
            end
            mn = (n < 0) ? -n : n;
            md = (d < 0) ? -d : d;
            return signed_mag((n < 0) != (d < 0), (mn << F) / md);
        endfunction

        // Evaluates both derivatives for an accepted cell and queues the result.
        function void note_cell(logic signed [W-1:0] u_in, logic signed [W-1:0] v_in);
            longint u;
            longint v;
            longint one;
            longint t;
            longint s;
            longint r;
            deriv_t e;
            u   = longint'(u_in);
            v   = longint'(v_in);
            one = longint'(1) << F;
            sat = 1'b0;
            t = mul(coef_a, u);
            t = add(mul(mul(sub(-one, coef_a), u), u), t);
            t = add(mul(mul(u, u), u), t);
            t = mul(coef_k, t);
            e.du = W'(sub(0, add(mul(u, v), t)));
            s = quot(v, add(coef_mu2, u));
            s = add(mul(coef_mu1, s), coef_eps);
            r = add(sub(sub(0, coef_a), one), u);
            r = mul(coef_k, r);
            r = sub(0, add(mul(u, r), v));
            e.dv   = W'(mul(r, s));
            e.flag = sat;
            pending.push_back(e);
        endfunction

        function void check_result(logic signed [W-1:0] du, logic signed [W-1:0] dv,
                                   logic flag);
            deriv_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result du=%h dv=%h flag=%b", $time, du, dv, flag);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (du !== e.du)
            begin
                $display("%0t: du mismatch expected %h actual %h", $time, e.du, du);
                errors++;
            end
            if (dv !== e.dv)
            begin
                $display("%0t: dv mismatch expected %h actual %h", $time, e.dv, dv);
                errors++;
            end
            if (flag !== e.flag)
            begin
                $display("%0t: range_flag mismatch expected %b actual %b", $time, e.flag, flag);
                errors++;
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [2:0]          cfg_index = REG_A;
    logic [W-1:0]        cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic signed [W-1:0] u_val = '0;
    logic signed [W-1:0] v_val = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic signed [W-1:0] du_val;
    logic signed [W-1:0] dv_val;
    logic                range_flag;

    rhs_scoreboard cell_sb = new();
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int quiet_cycles = 0;

    aliev_panfilov_rhs_top u_top (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < receiver_stall_pct);

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            cell_sb.check_result(du_val, dv_val, range_flag);
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (rst_n)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_cell(logic signed [W-1:0] u, logic signed [W-1:0] v);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        in_valid <= 1'b1;
        u_val    <= u;
        v_val    <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        cell_sb.note_cell(u, v);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (cell_sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Leaves the write enable high; the caller drops it after the last beat.
    task automatic write_coef(logic [2:0] idx, logic signed [W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cell_sb.set_coef(idx, val);
    endtask

    task automatic write_all(logic signed [W-1:0] a, logic signed [W-1:0] k,
                             logic signed [W-1:0] mu1, logic signed [W-1:0] mu2,
                             logic signed [W-1:0] eps);
        write_coef(REG_A, a);
        write_coef(REG_K, k);
        write_coef(REG_MU1, mu1);
        write_coef(REG_MU2, mu2);
        write_coef(REG_EPS, eps);
        cfg_we <= 1'b0;
    endtask

    // Mostly physiological values (u in [-1, 2], v in [-1, 3]), some full-range words, some zero divisors.
    task automatic random_cells(int count);
        logic signed [W-1:0] u;
        logic signed [W-1:0] v;
        int pick;
        repeat (count)
        begin
            pick = $urandom_range(9);
            if (pick < 6)
            begin
                u = W'(int'($urandom_range(3 << F)) - (1 << F));
                v = W'(int'($urandom_range(4 << F)) - (1 << F));
            end
            else if (pick < 9)
            begin
                u = $urandom;
                v = $urandom;
            end
            else
            begin
                u = W'(-cell_sb.coef_mu2);
                v = $urandom;
            end
            send_cell(u, v);
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: extremes of both fields and the zero-divisor cells at reset coefficients.
        send_cell('0, '0);
        send_cell(FX_MAX, FX_MAX);
        send_cell(FX_MIN, FX_MIN);
        send_cell(FX_MAX, FX_MIN);
        send_cell(FX_MIN, FX_MAX);
        send_cell(FX_ONE, '0);
        send_cell(FX_NONE, FX_ONE);
        send_cell(W'(-RST_MU2), FX_ONE);
        send_cell(W'(-RST_MU2), FX_NONE);
        send_cell(W'(-RST_MU2), '0);
        send_cell(W'(1), W'(-1));
        send_cell(W'(2 << F), W'(1 << (F - 1)));
        drain();

        write_all(FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX);
        send_cell('0, '0);
        send_cell(FX_MIN, FX_ONE);
        send_cell(FX_ONE, FX_MIN);
        send_cell(FX_MAX, FX_MAX);
        drain();

        write_all(FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MIN);
        send_cell('0, '0);
        send_cell(FX_MAX, FX_ONE);
        send_cell(FX_NONE, FX_MIN);
        send_cell(FX_MIN, FX_MAX);
        drain();

        write_all('0, '0, '0, '0, '0);
        send_cell('0, FX_ONE);
        send_cell(FX_ONE, FX_NONE);
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 78; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 78; end
                default: begin sender_idle_pct = 7; receiver_stall_pct = 7; end
            endcase
            if (phase == 0)
                write_all(RST_A, RST_K, RST_MU1, RST_MU2, RST_EPS);
            else if (phase % 2 == 0)
                write_all(W'($urandom_range(1 << F)), W'($urandom_range(16 << F)),
                          W'($urandom_range(1 << F)), W'($urandom_range(1 << F)),
                          W'($urandom_range(1 << 14)));
            else
                write_all($urandom, $urandom, $urandom, $urandom, $urandom);
            random_cells(100);
            drain();
        end

        if (cell_sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
